// ----- rtl/wsdefr_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Transfer payload types, parse phases, action codes and opcode classing.
// ----------------------------------------------------------------------------
package wsdefr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sync;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [2:0]  action;
        logic [3:0]  frame_opcode_out;
        logic [62:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_HALT    = 3'd5
    } t_phase;

    localparam logic [2:0] ACT_DATA     = 3'd0;
    localparam logic [2:0] ACT_CLOSE    = 3'd1;
    localparam logic [2:0] ACT_PONG     = 3'd2;
    localparam logic [2:0] ACT_UNKNOWN  = 3'd3;
    localparam logic [2:0] ACT_TOO_LONG = 3'd4;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] MASK_BYTES   = 4'd4;

    localparam logic [30:0] MAX_LEN_RESET = 31'd1048576;

    function automatic logic [2:0] classify(input logic [3:0] op);
        logic [2:0] act;
        case (op)
            OP_CONT, OP_TEXT, OP_BIN: act = ACT_DATA;
            OP_CLOSE:                 act = ACT_CLOSE;
            OP_PING, OP_PONG:         act = ACT_PONG;
            default:                  act = ACT_UNKNOWN;
        endcase
        return act;
    endfunction

endpackage

// ----- rtl/websocket_frame_deframer_unmask_top.sv -----
// A result is registered and shown on o_out_data in the cycle after the byte transfer that causes it.
// Throughput: one byte per cycle while i_out_ready does not stall the output; the single output register takes
// a new result in the same cycle that the held one is transferred.
// Reset (synchronous, i_rst_n low): parser waits for a first header byte,
// max_payload_len returns to 1048576, the output register empties.
// ----------------------------------------------------------------------------
// WebSocket frame deframer and unmasker
// Parses client frame headers byte by byte, checks length and opcode, and
// unmasks payload bytes; errors halt the parser until a sync byte arrives.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unmask_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wsdefr_pkg::t_in    i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wsdefr_pkg::t_out   o_out_data
);

    wsdefr_pkg::t_phase r_phase, n_phase, w_phase;
    logic [30:0]  r_max_len;
    logic [3:0]   r_opcode, n_opcode;
    logic [63:0]  r_len_acc, n_len_acc;
    logic [3:0]   r_ext_left, n_ext_left;
    logic [31:0]  r_mask_key, n_mask_key;
    logic [1:0]   r_mask_idx, n_mask_idx;
    logic [30:0]  r_bytes_rem, n_bytes_rem;
    logic         r_out_valid;
    wsdefr_pkg::t_out r_out, w_res;

    logic         w_in_xfer;
    logic         w_emit;
    logic [7:0]   w_byte;
    logic [6:0]   w_len7;
    logic [3:0]   w_ext_dec;
    logic [31:0]  w_key_next;
    logic [7:0]   w_mask_byte;
    logic         w_too_long;
    logic [2:0]   w_hdr_act;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_byte      = i_in_data.data_byte;
    assign w_phase     = i_in_data.sync ? wsdefr_pkg::PH_FIRST : r_phase;
    assign w_len7      = w_byte[6:0];
    assign w_ext_dec   = r_ext_left - 4'd1;
    assign w_key_next  = {r_mask_key[23:0], w_byte};
    assign w_mask_byte = r_mask_key[{~r_mask_idx, 3'b000} +: 8];
    assign w_too_long  = r_len_acc > {33'd0, r_max_len};
    assign w_hdr_act   = w_too_long ? wsdefr_pkg::ACT_TOO_LONG
                                    : wsdefr_pkg::classify(r_opcode);

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_len_acc   = r_len_acc;
        n_ext_left  = r_ext_left;
        n_mask_key  = r_mask_key;
        n_mask_idx  = r_mask_idx;
        n_bytes_rem = r_bytes_rem;
        case (w_phase)
            wsdefr_pkg::PH_LEN: begin
                if (w_len7 == wsdefr_pkg::LEN_CODE_16) begin
                    n_len_acc  = 64'd0;
                    n_ext_left = wsdefr_pkg::EXT_BYTES_16;
                    n_phase    = wsdefr_pkg::PH_EXT;
                end else if (w_len7 == wsdefr_pkg::LEN_CODE_64) begin
                    n_len_acc  = 64'd0;
                    n_ext_left = wsdefr_pkg::EXT_BYTES_64;
                    n_phase    = wsdefr_pkg::PH_EXT;
                end else begin
                    n_len_acc  = {57'd0, w_len7};
                    n_ext_left = wsdefr_pkg::MASK_BYTES;
                    n_phase    = wsdefr_pkg::PH_MASK;
                end
            end
            wsdefr_pkg::PH_EXT: begin
                n_len_acc = {r_len_acc[55:0], w_byte};
                if (w_ext_dec == 4'd0) begin
                    n_ext_left = wsdefr_pkg::MASK_BYTES;
                    n_phase    = wsdefr_pkg::PH_MASK;
                end else begin
                    n_ext_left = w_ext_dec;
                end
            end
            wsdefr_pkg::PH_MASK: begin
                n_mask_key = w_key_next;
                n_ext_left = w_ext_dec;
                if (w_ext_dec == 4'd0) begin
                    n_mask_idx  = 2'd0;
                    // length fits 31 bits whenever payload follows
                    n_bytes_rem = r_len_acc[30:0];
                    if (w_hdr_act == wsdefr_pkg::ACT_UNKNOWN ||
                        w_hdr_act == wsdefr_pkg::ACT_TOO_LONG) begin
                        n_phase = wsdefr_pkg::PH_HALT;
                    end else if (r_len_acc == 64'd0) begin
                        n_phase = wsdefr_pkg::PH_FIRST;
                    end else begin
                        n_phase = wsdefr_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsdefr_pkg::PH_PAYLOAD: begin
                n_mask_idx  = r_mask_idx + 2'd1;
                n_bytes_rem = r_bytes_rem - 31'd1;
                if (r_bytes_rem == 31'd1) begin
                    n_phase = wsdefr_pkg::PH_FIRST;
                end
            end
            wsdefr_pkg::PH_HALT: begin
                n_phase = r_phase;
            end
            default: begin
                n_opcode    = w_byte[3:0];
                n_len_acc   = 64'd0;
                n_ext_left  = 4'd0;
                n_mask_key  = 32'd0;
                n_mask_idx  = 2'd0;
                n_bytes_rem = 31'd0;
                n_phase     = wsdefr_pkg::PH_LEN;
            end
        endcase
    end

    always_comb begin
        w_emit                 = 1'b0;
        w_res.kind             = wsdefr_pkg::KIND_HEADER;
        w_res.action           = w_hdr_act;
        w_res.frame_opcode_out = r_opcode;
        w_res.payload_length   = r_len_acc[62:0];
        w_res.payload_byte     = 8'd0;
        w_res.last             = 1'b0;
        case (w_phase)
            wsdefr_pkg::PH_MASK: begin
                w_emit     = (w_ext_dec == 4'd0);
                w_res.last = w_too_long
                          || (w_hdr_act == wsdefr_pkg::ACT_UNKNOWN)
                          || (r_len_acc == 64'd0);
            end
            wsdefr_pkg::PH_PAYLOAD: begin
                w_emit             = 1'b1;
                w_res.kind         = wsdefr_pkg::KIND_PAYLOAD;
                w_res.action       = wsdefr_pkg::classify(r_opcode);
                w_res.payload_byte = w_byte ^ w_mask_byte;
                w_res.last         = (r_bytes_rem == 31'd1);
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= wsdefr_pkg::PH_FIRST;
            r_max_len   <= wsdefr_pkg::MAX_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (w_in_xfer) begin
                r_phase     <= n_phase;
                r_out_valid <= w_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload state needs no reset: a first header byte reloads it
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_opcode    <= n_opcode;
            r_len_acc   <= n_len_acc;
            r_ext_left  <= n_ext_left;
            r_mask_key  <= n_mask_key;
            r_mask_idx  <= n_mask_idx;
            r_bytes_rem <= n_bytes_rem;
            if (w_emit) begin
                r_out <= w_res;
            end
        end
    end

    a_sync_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_data.sync) |=> (r_phase == wsdefr_pkg::PH_LEN))
        else $error("sync byte did not restart header parse");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsdefr_pkg::PH_HALT && !i_in_data.sync) |-> !w_emit)
        else $error("halted parser produced a result");

    a_last_payload_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_phase == wsdefr_pkg::PH_PAYLOAD && r_bytes_rem == 31'd1)
        |=> (r_phase == wsdefr_pkg::PH_FIRST && r_out_valid && r_out.last))
        else $error("final payload byte did not close the frame");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule
